// ----- rtl/npnmf_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the reciprocal table for the negative pixel fix block.
// No dependencies.
package npnmf_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int PIXEL_BITS = 16;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CFG_W  = 7;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam int WIN_N   = 9;
  localparam int SUM_W   = PIXEL_BITS + 3;
  localparam int CNT_W   = 4;
  localparam int RECIP_K = SUM_W + 1;
  localparam int RECIP_W = RECIP_K + 1;
  localparam longint RECIP_ONE = longint'(1) << RECIP_K;

  localparam int NUM_SLOTS = 3;
  localparam int SLOT_CORE = 0;
  localparam int SLOT_EDGE = 1;
  localparam int SLOT_SELF = 2;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COL_W-1:0]             col_t;
  typedef logic [ROW_W-1:0]             row_t;
  typedef logic [CFG_W-1:0]             dim_t;
  typedef logic [SUM_W-1:0]             sum_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [RECIP_W-1:0]           recip_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    dim_t width;
    dim_t height;
    logic restart;
  } dims_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_MEAN,
    S_EMIT
  } state_t;

  // floor(2^K / d); d = 0 never divides (no valid neighbours gives 0)
  function automatic recip_t recip_of(cnt_t d);
    recip_t r;
    case (d)
      4'd1:    r = recip_t'(RECIP_ONE / 1);
      4'd2:    r = recip_t'(RECIP_ONE / 2);
      4'd3:    r = recip_t'(RECIP_ONE / 3);
      4'd4:    r = recip_t'(RECIP_ONE / 4);
      4'd5:    r = recip_t'(RECIP_ONE / 5);
      4'd6:    r = recip_t'(RECIP_ONE / 6);
      4'd7:    r = recip_t'(RECIP_ONE / 7);
      4'd8:    r = recip_t'(RECIP_ONE / 8);
      4'd9:    r = recip_t'(RECIP_ONE / 9);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/npnmf_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel beats in and result beats out.
// Depends on npnmf_pkg.
interface npnmf_in_if import npnmf_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface npnmf_out_if import npnmf_pkg::*; ();
  logic   valid;
  logic   ready;
  row_t   out_row;
  col_t   out_col;
  pixel_t out_value;
  logic   last_of_run;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_value,
                  input last_of_run, output ready);
endinterface

// ----- rtl/npnmf_ram.sv -----
`timescale 1ns / 1ps
// Generic single-clock RAM, one write and one read port, registered read data.
// No dependencies.
module npnmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/npnmf_mean.sv -----
`timescale 1ns / 1ps
// Floor mean of a window sum over a small count: reciprocal multiply, then one correction.
// Depends on npnmf_pkg.
module npnmf_mean import npnmf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  sum_t   sum,
  input  cnt_t   cnt,
  output logic   done,
  output pixel_t mean
);

  sum_t   sum_r;
  cnt_t   cnt_r;
  sum_t   q0_r;
  pixel_t mean_r;
  logic   v1_r;
  logic   v2_r;
  logic   done_r;

  logic [SUM_W+RECIP_W-1:0] prod;
  logic [SUM_W+CNT_W-1:0]   qd;
  logic [SUM_W+CNT_W-1:0]   rem;
  sum_t                     q_fix;

  assign prod  = (SUM_W+RECIP_W)'(sum_r) * (SUM_W+RECIP_W)'(recip_of(cnt_r));
  assign qd    = (SUM_W+CNT_W)'(q0_r) * (SUM_W+CNT_W)'(cnt_r);
  assign rem   = (SUM_W+CNT_W)'(sum_r) - qd;
  // no valid neighbours leaves the quotient at 0
  assign q_fix = ((cnt_r != '0) && (rem >= (SUM_W+CNT_W)'(cnt_r))) ? q0_r + sum_t'(1) : q0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= sum;
      cnt_r <= cnt;
    end
    if (v1_r) begin
      q0_r <= prod[RECIP_K +: SUM_W];
    end
    if (v2_r) begin
      mean_r <= pixel_t'(q_fix[PIXEL_BITS-1:0]);
    end
  end

  assign done = done_r;
  assign mean = mean_r;

endmodule

// ----- rtl/npnmf_cfg.sv -----
`timescale 1ns / 1ps
// APB register file: frame width and height, clamped for use, restart pulse on write.
// Depends on npnmf_pkg.
module npnmf_cfg import npnmf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output dims_t             dims
);

  dim_t     width_r;
  dim_t     height_r;
  logic     wr_en;
  reg_idx_t idx;

  function automatic dim_t clamp_dim(dim_t v, dim_t maxv);
    dim_t r;
    if (v == '0) begin
      r = dim_t'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dim_t'(1);
      height_r <= dim_t'(1);
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME_WIDTH:  width_r  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: height_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(width_r);
      REG_FRAME_HEIGHT: prdata = APB_DW'(height_r);
      default:          prdata = '0;
    endcase
  end

  assign dims.width   = clamp_dim(width_r, dim_t'(MAX_WIDTH));
  assign dims.height  = clamp_dim(height_r, dim_t'(MAX_HEIGHT));
  assign dims.restart = wr_en;

endmodule

// ----- rtl/negative_pixel_neighbour_mean_fix.sv -----
`timescale 1ns / 1ps
// Negative pixel fix over a 3x3 window: one pixel beat at a time, results lag by up to a row and a column.
// Depends on npnmf_pkg, npnmf_if, npnmf_ram, npnmf_mean and npnmf_cfg.
//
// Pixels enter in raster order; an interior pixel below zero leaves as the floor mean of the
// non-negative pixels of its uncorrected 3x3 window (0 if none), all others leave unchanged.
// Each result beat carries its row and column; last_of_run marks the final result caused by
// an input pixel, which gives 0 to 3 results. The two rows above sit in one line memory read
// once and written back once per pixel, and the mean goes through a reciprocal multiply and
// a correction stage. Writing either register restarts the frame; line contents are kept
// and are not cleared at reset, so no clearing pass is needed.
module negative_pixel_neighbour_mean_fix import npnmf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  npnmf_in_if.sink          in_if,
  npnmf_out_if.source       out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  state_t state_r, state_nxt;
  dims_t  dims;

  row_t   row_r;
  col_t   col_r;
  row_t   eff_row;
  col_t   eff_col;
  pixel_t pix_r;
  pixel_t wc_r [6];

  logic [NUM_SLOTS-1:0] pend_r;
  logic [NUM_SLOTS-1:0] pend_nxt;
  row_t                 slot_row_r [NUM_SLOTS];
  col_t                 slot_col_r [NUM_SLOTS];
  pixel_t               slot_val_r [NUM_SLOTS];
  logic                 fix_r;

  logic                      ram_re, ram_we;
  logic [2*PIXEL_BITS-1:0]   ram_rdata;
  pixel_t                    a_pix, b_pix;

  logic [NUM_SLOTS-1:0] emit_now;
  logic                 need_fix;
  sum_t                 win_sum;
  cnt_t                 win_cnt;
  pixel_t               win [WIN_N];

  logic   mean_start, mean_done;
  pixel_t mean;

  logic       in_acc, calc_en, out_load, out_last;
  logic [1:0] sel;

  logic   out_valid_r;
  row_t   out_row_r;
  col_t   out_col_r;
  pixel_t out_value_r;
  logic   out_last_r;

  npnmf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .dims    (dims)
  );

  npnmf_ram #(
    .WIDTH (2*PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (eff_col),
    .wdata ({b_pix, pix_r}),
    .re    (ram_re),
    .raddr (eff_col),
    .rdata (ram_rdata)
  );

  npnmf_mean u_mean (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mean_start),
    .sum   (win_sum),
    .cnt   (win_cnt),
    .done  (mean_done),
    .mean  (mean)
  );

  // Position of this pixel; out-of-range counters fall back to the frame origin
  always_comb begin
    if (CFG_W'(row_r) >= dims.height || CFG_W'(col_r) >= dims.width) begin
      eff_row = '0;
      eff_col = '0;
    end else begin
      eff_row = row_r;
      eff_col = col_r;
    end
  end

  assign a_pix = pixel_t'(ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS]);
  assign b_pix = pixel_t'(ram_rdata[PIXEL_BITS-1:0]);

  always_comb begin
    win[0] = wc_r[0]; win[1] = wc_r[1]; win[2] = a_pix;
    win[3] = wc_r[2]; win[4] = wc_r[3]; win[5] = b_pix;
    win[6] = wc_r[4]; win[7] = wc_r[5]; win[8] = pix_r;
  end

  always_comb begin
    win_sum = '0;
    win_cnt = '0;
    for (int k = 0; k < WIN_N; k++) begin
      if (!win[k][PIXEL_BITS-1]) begin
        win_sum = win_sum + sum_t'(unsigned'(win[k]));
        win_cnt = win_cnt + cnt_t'(1);
      end
    end
  end

  assign emit_now[SLOT_CORE] = (eff_row != '0) && (eff_col != '0);
  assign emit_now[SLOT_EDGE] = (eff_row != '0) && (CFG_W'(eff_col) == dims.width - dim_t'(1));
  assign emit_now[SLOT_SELF] = CFG_W'(eff_row) == dims.height - dim_t'(1);
  assign need_fix = (eff_row >= row_t'(2)) && (eff_col >= col_t'(2)) &&
                    wc_r[3][PIXEL_BITS-1];

  always_comb begin
    if (pend_r[SLOT_CORE]) begin
      sel = 2'(SLOT_CORE);
    end else if (pend_r[SLOT_EDGE]) begin
      sel = 2'(SLOT_EDGE);
    end else begin
      sel = 2'(SLOT_SELF);
    end
  end

  always_comb begin
    pend_nxt      = pend_r;
    pend_nxt[sel] = 1'b0;
  end

  assign out_last = (pend_nxt == '0);
  assign in_acc   = in_if.valid && in_if.ready;

  always_comb begin
    state_nxt   = state_r;
    in_if.ready = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    calc_en     = 1'b0;
    mean_start  = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_if.ready = 1'b1;
        ram_re      = in_if.valid;
        if (in_if.valid) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        ram_we  = 1'b1;
        calc_en = 1'b1;
        if (emit_now == '0) begin
          state_nxt = S_IDLE;
        end else if (emit_now[SLOT_CORE] && need_fix) begin
          mean_start = 1'b1;
          state_nxt  = S_MEAN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MEAN: begin
        if (mean_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_load = !out_valid_r || out_if.ready;
        if (out_load && out_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        wc_r[k] <= '0;
      end
    end else begin
      if (dims.restart) begin
        row_r <= '0;
        col_r <= '0;
      end else if (calc_en) begin
        if (CFG_W'(eff_col) + dim_t'(1) >= dims.width) begin
          col_r <= '0;
          if (CFG_W'(eff_row) + dim_t'(1) >= dims.height) begin
            row_r <= '0;
          end else begin
            row_r <= eff_row + row_t'(1);
          end
        end else begin
          col_r <= eff_col + col_t'(1);
          row_r <= eff_row;
        end
      end
      if (calc_en) begin
        wc_r[0] <= wc_r[1];
        wc_r[1] <= a_pix;
        wc_r[2] <= wc_r[3];
        wc_r[3] <= b_pix;
        wc_r[4] <= wc_r[5];
        wc_r[5] <= pix_r;
        pend_r  <= emit_now;
      end else if (out_load) begin
        pend_r <= pend_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r <= in_if.pixel_in;
    end
    if (calc_en) begin
      fix_r                 <= need_fix;
      slot_row_r[SLOT_CORE] <= eff_row - row_t'(1);
      slot_col_r[SLOT_CORE] <= eff_col - col_t'(1);
      slot_val_r[SLOT_CORE] <= wc_r[3];
      slot_row_r[SLOT_EDGE] <= eff_row - row_t'(1);
      slot_col_r[SLOT_EDGE] <= eff_col;
      slot_val_r[SLOT_EDGE] <= b_pix;
      slot_row_r[SLOT_SELF] <= eff_row;
      slot_col_r[SLOT_SELF] <= eff_col;
      slot_val_r[SLOT_SELF] <= pix_r;
    end
    if (out_load) begin
      out_row_r   <= slot_row_r[sel];
      out_col_r   <= slot_col_r[sel];
      out_value_r <= (sel == 2'(SLOT_CORE) && fix_r) ? mean : slot_val_r[sel];
      out_last_r  <= out_last;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_row     = out_row_r;
  assign out_if.out_col     = out_col_r;
  assign out_if.out_value   = out_value_r;
  assign out_if.last_of_run = out_last_r;

  a_ram_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("line memory read and write in the same cycle");

  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_CALC)
    else $error("accepted beat not processed next cycle");

  a_mean_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mean_done |-> state_r == S_MEAN)
    else $error("mean completed outside wait state");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last) |=> state_r == S_IDLE)
    else $error("run did not end after last result");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !out_last) |=> (state_r == S_EMIT && pend_r != '0))
    else $error("pending results lost");

endmodule
